### hdl/adir_pkg.sv
// ----------------------------------------------------------------------------
// adir_pkg
// Shared constants, codes, sideband types and the CORDIC angle table of the
// angular direction sampler.
// ----------------------------------------------------------------------------
package adir_pkg;

  localparam int FRAC_BITS     = 22;
  localparam int RAND_BITS     = 24;
  localparam int CORDIC_STAGES = 24;
  localparam int VAL_W         = FRAC_BITS + 2;
  localparam int SQ_W          = 2 * VAL_W;

  localparam logic signed [VAL_W:0] ONE_Q = (VAL_W + 1)'(1) <<< FRAC_BITS;
  localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

  // mode register codes; the unused code behaves as uniform
  localparam logic [1:0] MODE_UNIFORM = 2'd0;
  localparam logic [1:0] MODE_FWD     = 2'd1;
  localparam logic [1:0] MODE_BWD     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_COS_LOW  = 2'd1;
  localparam logic [1:0] REG_COS_HIGH = 2'd2;

  // carried alongside the first square root
  typedef struct packed {
    logic [1:0]               mode;
    logic [RAND_BITS-1:0]     u2;
    logic signed [VAL_W:0]    cz;
  } polar_meta_t;

  // carried alongside the second square root
  typedef struct packed {
    logic [RAND_BITS-1:0]     u2;
    logic signed [VAL_W-1:0]  cz;
  } dir_meta_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10679838;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      24: t = 32'd41;
      25: t = 32'd20;
      26: t = 32'd10;
      27: t = 32'd5;
      28: t = 32'd3;
      29: t = 32'd1;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

### hdl/adir_polar.sv
// ----------------------------------------------------------------------------
// adir_polar
// Front pipeline: clamps the cosine window, forms the squared bounds and
// scales the window by the polar fraction into a square-root radicand.
// ----------------------------------------------------------------------------
module adir_polar
  import adir_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [RAND_BITS-1:0]        u1,
  input  logic [RAND_BITS-1:0]        u2,
  input  logic [1:0]                  mode,
  input  logic signed [VAL_W-1:0]     cos_low,
  input  logic signed [VAL_W-1:0]     cos_high,
  output logic                        rad_valid,
  output logic [SQ_W-1:0]             rad,
  output polar_meta_t                 meta
);

  localparam int DW = SQ_W + 2;

  function automatic logic signed [VAL_W:0] clamp_cos(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W:0] w;
    w = VAL_W'(v) == v ? {v[VAL_W-1], v} : {v[VAL_W-1], v};
    if (w > ONE_Q) return ONE_Q;
    if (w < -ONE_Q) return -ONE_Q;
    return w;
  endfunction

  // stage 1
  logic                    v1_r;
  logic [RAND_BITS-1:0]    u1_1_r, u2_1_r;
  logic [1:0]              mode1_r;
  logic signed [VAL_W:0]   c1_1_r, c2_1_r;
  logic [VAL_W-1:0]        a1_r, a2_r;
  logic signed [VAL_W:0]   c1_nxt, c2_nxt, a1_nxt, a2_nxt;

  always_comb begin
    c1_nxt = clamp_cos(cos_low);
    c2_nxt = clamp_cos(cos_high);
    if (mode == MODE_BWD) begin
      a1_nxt = ONE_Q - c1_nxt;
      a2_nxt = ONE_Q - c2_nxt;
    end else begin
      a1_nxt = c1_nxt + ONE_Q;
      a2_nxt = c2_nxt + ONE_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      u1_1_r  <= u1;
      u2_1_r  <= u2;
      mode1_r <= mode;
      c1_1_r  <= c1_nxt;
      c2_1_r  <= c2_nxt;
      a1_r    <= a1_nxt[VAL_W-1:0];
      a2_r    <= a2_nxt[VAL_W-1:0];
    end
  end

  // stage 2: squares
  logic                    v2_r;
  logic [RAND_BITS-1:0]    u1_2_r, u2_2_r;
  logic [1:0]              mode2_r;
  logic signed [VAL_W:0]   c1_2_r;
  logic signed [VAL_W+1:0] dcos_r;
  logic [SQ_W-1:0]         sq1_r, sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      u1_2_r  <= u1_1_r;
      u2_2_r  <= u2_1_r;
      mode2_r <= mode1_r;
      c1_2_r  <= c1_1_r;
      dcos_r  <= {c2_1_r[VAL_W], c2_1_r} - {c1_1_r[VAL_W], c1_1_r};
      sq1_r   <= a1_r * a1_r;
      sq2_r   <= a2_r * a2_r;
    end
  end

  // stage 3: signed span and base
  logic                    v3_r;
  logic [RAND_BITS-1:0]    u1_3_r, u2_3_r;
  logic [1:0]              mode3_r;
  logic                    neg_r;
  logic [SQ_W-1:0]         mag_r;
  logic signed [DW-1:0]    base_r;
  logic signed [DW-1:0]    diff_nxt, base_nxt;

  always_comb begin
    case (mode2_r)
      MODE_FWD: begin
        diff_nxt = $signed({2'b00, sq2_r}) - $signed({2'b00, sq1_r});
        base_nxt = $signed({2'b00, sq1_r});
      end
      MODE_BWD: begin
        // a1^2 - scale(a1^2 - a2^2) is a1^2 + scale(a2^2 - a1^2)
        diff_nxt = $signed({2'b00, sq2_r}) - $signed({2'b00, sq1_r});
        base_nxt = $signed({2'b00, sq1_r});
      end
      default: begin
        diff_nxt = DW'(dcos_r);
        base_nxt = DW'(c1_2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      u1_3_r  <= u1_2_r;
      u2_3_r  <= u2_2_r;
      mode3_r <= mode2_r;
      neg_r   <= diff_nxt[DW-1];
      mag_r   <= diff_nxt[DW-1] ? SQ_W'(-diff_nxt) : SQ_W'(diff_nxt);
      base_r  <= base_nxt;
    end
  end

  // stage 4: span times fraction as two partial products
  logic                    v4_r;
  logic [RAND_BITS-1:0]    u2_4_r;
  logic [1:0]              mode4_r;
  logic                    neg4_r;
  logic signed [DW-1:0]    base4_r;
  logic [SQ_W-1:0]         ph_r, pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      u2_4_r  <= u2_3_r;
      mode4_r <= mode3_r;
      neg4_r  <= neg_r;
      base4_r <= base_r;
      ph_r    <= mag_r[SQ_W-1:SQ_W-RAND_BITS] * u1_3_r;
      pl_r    <= SQ_W'(mag_r[SQ_W-RAND_BITS-1:0]) * SQ_W'(u1_3_r);
    end
  end

  // stage 5: combine and saturate the radicand
  logic                    v5_r;
  logic [SQ_W-1:0]         rad_r;
  polar_meta_t             meta_r;
  logic signed [DW-1:0]    sc_nxt, val_nxt;

  always_comb begin
    sc_nxt  = $signed({2'b00, ph_r}) + $signed(DW'(pl_r >> RAND_BITS));
    val_nxt = neg4_r ? base4_r - sc_nxt : base4_r + sc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      rad_r       <= val_nxt[DW-1] ? '0 : val_nxt[SQ_W-1:0];
      meta_r.mode <= mode4_r;
      meta_r.u2   <= u2_4_r;
      meta_r.cz   <= val_nxt[VAL_W:0];
    end
  end

  assign rad_valid = v5_r;
  assign rad       = rad_r;
  assign meta      = meta_r;

endmodule

### hdl/adir_isqrt.sv
// ----------------------------------------------------------------------------
// adir_isqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module adir_isqrt
  import adir_pkg::*;
#(
  parameter int N    = 24,
  parameter int SB_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*N-1:0]    rad,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [N-1:0]      root,
  output logic [SB_W-1:0]   out_sb
);

  logic            vld_r [N];
  logic [2*N-1:0]  rem_r [N];
  logic [2*N-1:0]  res_r [N];
  logic [SB_W-1:0] sb_r  [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [2*N-1:0] BIT = (2*N)'(1) << (2 * (N - 1 - i));
    logic            vin;
    logic [2*N-1:0]  rin, qin, trial;
    logic [SB_W-1:0] sbin;

    if (i == 0) begin : g_first
      assign vin  = in_valid;
      assign rin  = rad;
      assign qin  = '0;
      assign sbin = in_sb;
    end else begin : g_next
      assign vin  = vld_r[i-1];
      assign rin  = rem_r[i-1];
      assign qin  = res_r[i-1];
      assign sbin = sb_r[i-1];
    end

    assign trial = qin + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vin;
      end
      if (en) begin
        sb_r[i] <= sbin;
        if (rin >= trial) begin
          rem_r[i] <= rin - trial;
          res_r[i] <= (qin >> 1) + BIT;
        end else begin
          rem_r[i] <= rin;
          res_r[i] <= qin >> 1;
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign root      = res_r[N-1][N-1:0];
  assign out_sb    = sb_r[N-1];

endmodule

### hdl/adir_cordic.sv
// ----------------------------------------------------------------------------
// adir_cordic
// Gain pre-scale, half-turn fold and pipelined CORDIC rotation of (sin, 0)
// by the azimuth; clamps the result to one.
// ----------------------------------------------------------------------------
module adir_cordic
  import adir_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [VAL_W-2:0]         sn,
  input  dir_meta_t                in_meta,
  output logic                     out_valid,
  output logic signed [VAL_W-1:0]  dir_x,
  output logic signed [VAL_W-1:0]  dir_y,
  output logic signed [VAL_W-1:0]  dir_z
);

  localparam int XW = 32;
  localparam int ZW = 34;
  localparam int PW = VAL_W - 1 + 31;

  // gain product
  logic                   g_v_r;
  logic [PW-1:0]          prod_r;
  logic signed [ZW-1:0]   g_z_r;
  logic signed [VAL_W-1:0] g_cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= in_valid;
    end
    if (en) begin
      prod_r <= PW'(sn) * PW'(GAIN_Q31);
      g_z_r  <= ZW'($signed({in_meta.u2, (32 - RAND_BITS)'(0)}));
      g_cz_r <= in_meta.cz;
    end
  end

  // fold into a quarter turn either side
  localparam logic signed [ZW-1:0] QTR  = ZW'(1) <<< 30;
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< 31;

  logic                    vld_r [STAGES+1];
  logic signed [XW-1:0]    x_r   [STAGES+1];
  logic signed [XW-1:0]    y_r   [STAGES+1];
  logic signed [ZW-1:0]    z_r   [STAGES+1];
  logic signed [VAL_W-1:0] cz_r  [STAGES+1];
  logic signed [XW-1:0]    x0_nxt;

  assign x0_nxt = $signed(XW'(prod_r >> 31));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= g_v_r;
    end
    if (en) begin
      y_r[0]  <= '0;
      cz_r[0] <= g_cz_r;
      if (g_z_r > QTR) begin
        x_r[0] <= -x0_nxt;
        z_r[0] <= g_z_r - HALF;
      end else if (g_z_r < -QTR) begin
        x_r[0] <= -x0_nxt;
        z_r[0] <= g_z_r + HALF;
      end else begin
        x_r[0] <= x0_nxt;
        z_r[0] <= g_z_r;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = $signed({2'b00, atan_turn(i)});
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        cz_r[i+1] <= cz_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - AT;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + AT;
        end
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] clamp_out(input logic signed [XW-1:0] v);
    if (v > XW'(ONE_Q)) return VAL_W'(ONE_Q);
    if (v < -XW'(ONE_Q)) return -VAL_W'(ONE_Q);
    return v[VAL_W-1:0];
  endfunction

  logic                    o_v_r;
  logic signed [VAL_W-1:0] ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= vld_r[STAGES];
    end
    if (en) begin
      ox_r <= clamp_out(x_r[STAGES]);
      oy_r <= clamp_out(y_r[STAGES]);
      oz_r <= cz_r[STAGES];
    end
  end

  assign out_valid = o_v_r;
  assign dir_x     = ox_r;
  assign dir_y     = oy_r;
  assign dir_z     = oz_r;

endmodule

### hdl/angular_direction_sampler.sv
// ----------------------------------------------------------------------------
// angular_direction_sampler
// Turns two uniform random fractions into a unit direction vector.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per pair of fractions (rand_polar, rand_azimuth).
//   out_* : one transaction per direction (dir_x, dir_y, dir_z), signed Q1.22,
//           in input order.
//   cfg_* : write mode, cos_low, cos_high by index while the block is idle.
// Throughput: one item per cycle while the output buffer has room. Stages: 5 front
// stages, 24 and 23 stages of the two square roots, 2 cosine stages, 1 gain, 1 fold,
// CORDIC_STAGES rotations and 1 clamp stage, then the 2-entry output buffer.
// The whole pipeline advances together; it holds while the output buffer is
// full, and a stalled receiver therefore stops intake after two results wait.
// Reset empties the pipeline and the buffer and loads mode uniform and the
// window [-1, 1].
// ----------------------------------------------------------------------------
module angular_direction_sampler
  import adir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // rand_polar[23:0], rand_azimuth[47:24]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // dir_x[23:0], dir_y[47:24], dir_z[71:48]
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [VAL_W-1:0]      cfg_wdata
);

  // configuration
  logic [1:0]              mode_r;
  logic signed [VAL_W-1:0] cos_low_r, cos_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_UNIFORM;
      cos_low_r  <= -VAL_W'(ONE_Q);
      cos_high_r <= VAL_W'(ONE_Q);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     mode_r     <= cfg_wdata[1:0];
        REG_COS_LOW:  cos_low_r  <= cfg_wdata;
        REG_COS_HIGH: cos_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic       en;
  logic [1:0] cnt_r;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  // front
  logic            rad_valid;
  logic [SQ_W-1:0] rad;
  polar_meta_t     pmeta;

  adir_polar u_polar (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .u1       (in_tdata[23:0]),
    .u2       (in_tdata[47:24]),
    .mode     (mode_r),
    .cos_low  (cos_low_r),
    .cos_high (cos_high_r),
    .rad_valid(rad_valid),
    .rad      (rad),
    .meta     (pmeta)
  );

  logic             r1_valid;
  logic [VAL_W-1:0] r1;
  polar_meta_t      r1_meta;

  adir_isqrt #(.N(VAL_W), .SB_W($bits(polar_meta_t))) u_sqrt_cos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rad_valid),
    .rad      (rad),
    .in_sb    (pmeta),
    .out_valid(r1_valid),
    .root     (r1),
    .out_sb   (r1_meta)
  );

  // cosine from the root, then the sine radicand
  logic                    q1_v_r;
  logic signed [VAL_W-1:0] q1_cz_r;
  logic [RAND_BITS-1:0]    q1_u2_r;
  logic signed [VAL_W+1:0] cz_nxt;

  always_comb begin
    case (r1_meta.mode)
      MODE_FWD: cz_nxt = $signed({2'b00, r1}) - (VAL_W + 2)'(ONE_Q);
      MODE_BWD: cz_nxt = (VAL_W + 2)'(ONE_Q) - $signed({2'b00, r1});
      default:  cz_nxt = (VAL_W + 2)'(r1_meta.cz);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_v_r <= 1'b0;
    end else if (en) begin
      q1_v_r <= r1_valid;
    end
    if (en) begin
      q1_u2_r <= r1_meta.u2;
      if (cz_nxt > (VAL_W + 2)'(ONE_Q)) begin
        q1_cz_r <= VAL_W'(ONE_Q);
      end else if (cz_nxt < -(VAL_W + 2)'(ONE_Q)) begin
        q1_cz_r <= -VAL_W'(ONE_Q);
      end else begin
        q1_cz_r <= cz_nxt[VAL_W-1:0];
      end
    end
  end

  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

  logic                    q2_v_r;
  logic [SQ_W-3:0]         q2_rad_r;
  dir_meta_t               q2_meta_r;
  logic signed [SQ_W-1:0]  czsq;

  assign czsq = q1_cz_r * q1_cz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_v_r <= 1'b0;
    end else if (en) begin
      q2_v_r <= q1_v_r;
    end
    if (en) begin
      q2_rad_r     <= (SQ_W-2)'(ONE_SQ - SQ_W'(czsq));
      q2_meta_r.u2 <= q1_u2_r;
      q2_meta_r.cz <= q1_cz_r;
    end
  end

  logic             r2_valid;
  logic [VAL_W-2:0] sn;
  dir_meta_t        r2_meta;

  adir_isqrt #(.N(VAL_W - 1), .SB_W($bits(dir_meta_t))) u_sqrt_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (q2_v_r),
    .rad      (q2_rad_r),
    .in_sb    (q2_meta_r),
    .out_valid(r2_valid),
    .root     (sn),
    .out_sb   (r2_meta)
  );

  logic                    d_valid;
  logic signed [VAL_W-1:0] dx, dy, dz;

  adir_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (r2_valid),
    .sn       (sn),
    .in_meta  (r2_meta),
    .out_valid(d_valid),
    .dir_x    (dx),
    .dir_y    (dy),
    .dir_z    (dz)
  );

  // output buffer: two entries so intake continues while one result waits
  logic [71:0] buf_r [2];
  logic        wp_r, rp_r;
  logic        push, pop;

  assign push = en & d_valid;
  assign pop  = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      buf_r[wp_r] <= {dz, dy, dx};
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[rp_r];

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> (cnt_r == 2'd2))
    else $error("output buffer left full without a pop");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wp_r == rp_r))
    else $error("buffer pointers disagree with count");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (cnt_r != 2'd2))
    else $error("intake open while buffer full");
`endif

endmodule

### verif/adir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adir_checker
// Watches the configuration port and both streams of the angular direction
// sampler, predicts each direction vector and compares it field by field.
// ----------------------------------------------------------------------------
module adir_checker
  import adir_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [47:0]      in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [71:0]      out_tdata,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [VAL_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending_dirs
);

  localparam longint ONE = 64'sd1 << FRAC_BITS;

  logic [1:0]       mode_q;
  logic [VAL_W-1:0] cos_low_q;
  logic [VAL_W-1:0] cos_high_q;
  logic [71:0]      dir_queue[$];

  function automatic longint clamp_unit(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  // floor(|d| * u / 2^RAND_BITS) with the sign of d
  function automatic longint scale_by_frac(longint d, longint u);
    logic [127:0] p;
    longint m;
    m = (d < 0) ? -d : d;
    p = 128'(m) * 128'(u);
    m = longint'(p >> RAND_BITS);
    return (d < 0) ? -m : m;
  endfunction

  function automatic longint floor_sqrt(longint a);
    longint r;
    longint b;
    if (a <= 0) return 0;
    r = 0;
    b = 64'sd1 << 62;
    while (b > a) b = b >>> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [71:0] predict_direction(logic [47:0] item);
    longint u1, u2, c1, c2, a1, a2, cz, sn, x, y, z, dx, dy, xc, yc;
    u1 = longint'(item[23:0]);
    u2 = longint'(item[47:24]);
    c1 = clamp_unit(longint'($signed(cos_low_q)));
    c2 = clamp_unit(longint'($signed(cos_high_q)));
    case (mode_q)
      MODE_FWD: begin
        a1 = c1 + ONE;
        a2 = c2 + ONE;
        cz = floor_sqrt(a1 * a1 + scale_by_frac(a2 * a2 - a1 * a1, u1)) - ONE;
      end
      MODE_BWD: begin
        a1 = ONE - c1;
        a2 = ONE - c2;
        cz = ONE - floor_sqrt(a1 * a1 - scale_by_frac(a1 * a1 - a2 * a2, u1));
      end
      default: cz = c1 + scale_by_frac(c2 - c1, u1);
    endcase
    cz = clamp_unit(cz);
    sn = floor_sqrt(ONE * ONE - cz * cz);
    x = (sn * longint'(GAIN_Q31)) >>> 31;
    y = 0;
    z = u2 << (32 - RAND_BITS);
    if (z >= (64'sd1 << 31)) z = z - (64'sd1 << 32);
    // fold into a quarter turn either side of zero
    if (z > (64'sd1 << 30)) begin
      x = -x;
      z = z - (64'sd1 << 31);
    end else if (z < -(64'sd1 << 30)) begin
      x = -x;
      z = z + (64'sd1 << 31);
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_turn(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_turn(i));
      end
    end
    xc = clamp_unit(x);
    yc = clamp_unit(y);
    return {cz[23:0], yc[23:0], xc[23:0]};
  endfunction

  always_ff @(posedge clk) begin
    logic [71:0] want;
    if (!rst_n) begin
      mode_q     <= MODE_UNIFORM;
      cos_low_q  <= VAL_W'(-ONE);
      cos_high_q <= VAL_W'(ONE);
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     mode_q     <= cfg_wdata[1:0];
          REG_COS_LOW:  cos_low_q  <= cfg_wdata;
          REG_COS_HIGH: cos_high_q <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) dir_queue.push_back(predict_direction(in_tdata));
      if (out_tvalid && out_tready) begin
        if (dir_queue.size() == 0) begin
          $error("unexpected direction %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = dir_queue.pop_front();
          if (want != out_tdata) fail_count <= fail_count + 1;
          if (want[23:0] != out_tdata[23:0])
            $error("dir_x expected %0d actual %0d", $signed(want[23:0]),
                   $signed(out_tdata[23:0]));
          if (want[47:24] != out_tdata[47:24])
            $error("dir_y expected %0d actual %0d", $signed(want[47:24]),
                   $signed(out_tdata[47:24]));
          if (want[71:48] != out_tdata[71:48])
            $error("dir_z expected %0d actual %0d", $signed(want[71:48]),
                   $signed(out_tdata[71:48]));
        end
      end
    end
  end

  assign pending_dirs = dir_queue.size();

endmodule

### verif/tb_angular_direction_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_angular_direction_sampler
// Drives random and corner fraction pairs through several sampling modes and
// cosine windows, with random gaps and back-pressure; adir_checker judges.
// ----------------------------------------------------------------------------
module tb_angular_direction_sampler;
  import adir_pkg::*;

  localparam int ONE_I = 1 << FRAC_BITS;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [47:0]      in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [71:0]      out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [VAL_W-1:0] cfg_wdata;
  int               fail_count;
  int               pending_dirs;
  bit               calm;
  bit               hold_rx;

  angular_direction_sampler u_dut (.*);

  adir_checker u_chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_rx && (calm || $urandom_range(99) >= 7);
  end

  task automatic write_reg(logic [1:0] idx, logic [VAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_window(logic [1:0] mode, int lo, int hi);
    write_reg(REG_MODE, VAL_W'(mode));
    write_reg(REG_COS_LOW, VAL_W'(lo));
    write_reg(REG_COS_HIGH, VAL_W'(hi));
  endtask

  // leave tvalid high after the transaction so pairs can follow back to back
  task automatic send_pair(logic [23:0] polar, logic [23:0] azim);
    while (!calm && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {azim, polar};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dirs != 0) @(posedge clk);
  endtask

  task automatic random_pairs(int n);
    for (int i = 0; i < n; i++) send_pair(24'($urandom), 24'($urandom));
  endtask

  int lo, hi;

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    calm = 1'b0; hold_rx = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner fractions under reset window, uniform
    send_pair(24'h000000, 24'h000000);
    send_pair(24'hFFFFFF, 24'hFFFFFF);
    send_pair(24'h800000, 24'h400000);
    send_pair(24'h7FFFFF, 24'hC00000);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'hAAAAAA, 24'h555555);
    for (int m = 1; m < 4; m++) begin
      drain;
      set_window(2'(m), -ONE_I, ONE_I);
      send_pair(24'h000000, 24'h200000);
      send_pair(24'hFFFFFF, 24'hE00000);
      send_pair(24'h800000, 24'h400001);
    end
    // bounds beyond one, reversed window, fixed cosine, bogus index
    drain;
    set_window(MODE_FWD, 24'h800000, 24'h7FFFFF);
    write_reg(2'd3, 24'hFFFFFF);
    send_pair(24'h123456, 24'h3FFFFF);
    send_pair(24'hFFFFFF, 24'hBFFFFF);
    drain;
    set_window(MODE_BWD, ONE_I / 2, -ONE_I / 2);
    send_pair(24'hFFFFFF, 24'h654321);
    send_pair(24'h000001, 24'h000001);
    drain;
    set_window(MODE_UNIFORM, ONE_I / 3, ONE_I / 3);
    send_pair(24'h9ABCDE, 24'hFEDCBA);

    for (int ph = 0; ph < 8; ph++) begin
      drain;
      lo = $urandom_range(2 * ONE_I) - ONE_I;
      hi = $urandom_range(2 * ONE_I) - ONE_I;
      if (ph == 0) begin lo = -ONE_I; hi = ONE_I; end
      if (ph == 1) begin lo = ONE_I; hi = -ONE_I; end
      set_window(2'(ph % 4), lo, hi);
      calm = (ph == 3);
      if (ph == 5) begin
        hold_rx = 1'b1;
        fork
          begin repeat (300) @(posedge clk); hold_rx = 1'b0; end
          random_pairs(105);
        join
      end else begin
        random_pairs(105);
      end
    end
    calm = 1'b0;
    drain;
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
